// File: design/scpwm_pkg.sv
`default_nettype none

package scpwm_pkg;

    typedef logic [1:0]  op_t;
    typedef logic [11:0] cmp_t;

    localparam op_t OP_TICK  = 2'd0;
    localparam op_t OP_WRITE = 2'd1;
    localparam op_t OP_READ  = 2'd2;

    localparam logic [7:0] ADDR_MODE1    = 8'h00;
    localparam logic [7:0] ADDR_MODE2    = 8'h01;
    localparam logic [7:0] ADDR_LED_BASE = 8'h06;
    localparam logic [7:0] ADDR_ALL_BASE = 8'hFA;
    localparam logic [7:0] ADDR_ALL_LAST = 8'hFD;
    localparam logic [7:0] ADDR_PRESCALE = 8'hFE;

    localparam int unsigned SLEEP_POS = 4;

    localparam logic [7:0] MODE1_RESET    = 8'h11;
    localparam logic [7:0] MODE2_RESET    = 8'h04;
    localparam logic [7:0] PRESCALE_RESET = 8'h1E;

    localparam int unsigned MAX_CHANNELS = 16;

    // Merge one byte into a compare value; sel_high picks bits 11..8.
    function automatic cmp_t put_led_byte(input cmp_t cur, input logic sel_high,
                                          input logic [7:0] b);
        cmp_t r;
        if (sel_high)
        begin
            r = {b[3:0], cur[7:0]};
        end
        else
        begin
            r = {cur[11:8], b};
        end
        return r;
    endfunction

    function automatic logic [7:0] get_led_byte(input cmp_t cur, input logic sel_high);
        logic [7:0] r;
        if (sel_high)
        begin
            r = {4'h0, cur[11:8]};
        end
        else
        begin
            r = cur[7:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/scpwm_req_if.sv
`default_nettype none

interface scpwm_req_if;
    import scpwm_pkg::*;

    logic       valid;
    logic       ready;
    op_t        op;
    logic [7:0] reg_addr;
    logic [7:0] wr_byte;

    modport source (output valid, output op, output reg_addr, output wr_byte, input ready);
    modport sink   (input valid, input op, input reg_addr, input wr_byte, output ready);
endinterface

`default_nettype wire

// File: design/scpwm_rsp_if.sv
`default_nettype none

interface scpwm_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  rd_byte;
    logic [15:0] pwm_lines;

    modport source (output valid, output rd_byte, output pwm_lines, input ready);
    modport sink   (input valid, input rd_byte, input pwm_lines, output ready);
endinterface

`default_nettype wire

// File: design/sixteen_channel_pwm_register_device.sv
// Register-level model of a 16-channel, 12-bit PWM controller.
// The req channel carries one item per transfer: an oscillator tick, a
// register write or a register read (op, reg_addr, wr_byte). The rsp channel
// returns exactly one result per item: rd_byte (read data, zero for ticks,
// writes and unmapped addresses) and pwm_lines, the channel levels after the
// item has taken effect.
// The result of an item accepted at a clock edge is registered in the output
// register and is valid on rsp right after that edge.
// Throughput is one item per cycle while the receiver takes each result; the
// limit is the single output register, which is refilled in the same cycle it is drained.
// When the receiver stalls, the result stays in the output register and req
// keeps ready low until that result has been transferred.
// Reset puts the device to sleep (mode1 0x11, mode2 0x04, prescale 0x1E),
// clears all on and off compares and both counters, and empties the output
// register. The block is ready for items in the first cycle after reset.
`default_nettype none

module sixteen_channel_pwm_register_device #(
    parameter int unsigned NUM_CHANNELS = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    scpwm_req_if.sink  req,
    scpwm_rsp_if.source rsp
);
    import scpwm_pkg::*;

    localparam logic [7:0] LED_END = 8'(32'(ADDR_LED_BASE) + 4 * NUM_CHANNELS);

    logic [7:0]  mode1_reg, mode1_next;
    logic [7:0]  mode2_reg, mode2_next;
    logic [7:0]  prescale_reg, prescale_next;
    logic [7:0]  div_reg, div_next;
    cmp_t        period_reg, period_next;
    cmp_t        on_reg  [NUM_CHANNELS];
    cmp_t        on_next [NUM_CHANNELS];
    cmp_t        off_reg [NUM_CHANNELS];
    cmp_t        off_next[NUM_CHANNELS];

    logic        out_valid_reg;
    logic [7:0]  rd_byte_reg, rd_byte_next;
    logic [15:0] lines_reg, lines_next;

    logic        accept;
    logic        asleep;
    logic [7:0]  led_off;
    logic [7:0]  all_off;
    logic        led_hit;
    logic        all_hit;

    assign req.ready     = !out_valid_reg || rsp.ready;
    assign accept        = req.valid && req.ready;
    assign asleep        = mode1_reg[SLEEP_POS];
    assign led_off       = req.reg_addr - ADDR_LED_BASE;
    assign all_off       = req.reg_addr - ADDR_ALL_BASE;
    assign led_hit       = (req.reg_addr >= ADDR_LED_BASE) && (req.reg_addr < LED_END);
    assign all_hit       = (req.reg_addr >= ADDR_ALL_BASE) && (req.reg_addr <= ADDR_ALL_LAST);

    assign rsp.valid     = out_valid_reg;
    assign rsp.rd_byte   = rd_byte_reg;
    assign rsp.pwm_lines = lines_reg;

    always_comb
    begin
        mode1_next    = mode1_reg;
        mode2_next    = mode2_reg;
        prescale_next = prescale_reg;
        div_next      = div_reg;
        period_next   = period_reg;
        rd_byte_next  = 8'h00;
        for (int n = 0; n < NUM_CHANNELS; n++)
        begin
            on_next[n]  = on_reg[n];
            off_next[n] = off_reg[n];
        end

        case (req.op)
            OP_TICK:
            begin
                if (!asleep)
                begin
                    if (div_reg >= prescale_reg)
                    begin
                        div_next    = 8'h00;
                        period_next = period_reg + 12'd1;
                    end
                    else
                    begin
                        div_next = div_reg + 8'd1;
                    end
                end
            end
            OP_WRITE:
            begin
                if (req.reg_addr == ADDR_MODE1)
                begin
                    mode1_next = req.wr_byte;
                end
                else if (req.reg_addr == ADDR_MODE2)
                begin
                    mode2_next = req.wr_byte;
                end
                else if (led_hit)
                begin
                    for (int n = 0; n < NUM_CHANNELS; n++)
                    begin
                        if (led_off[7:2] == 6'(n))
                        begin
                            if (led_off[1])
                            begin
                                off_next[n] = put_led_byte(off_reg[n], led_off[0], req.wr_byte);
                            end
                            else
                            begin
                                on_next[n] = put_led_byte(on_reg[n], led_off[0], req.wr_byte);
                            end
                        end
                    end
                end
                else if (all_hit)
                begin
                    // Broadcast: the same byte lands in every channel.
                    for (int n = 0; n < NUM_CHANNELS; n++)
                    begin
                        if (all_off[1])
                        begin
                            off_next[n] = put_led_byte(off_reg[n], all_off[0], req.wr_byte);
                        end
                        else
                        begin
                            on_next[n] = put_led_byte(on_reg[n], all_off[0], req.wr_byte);
                        end
                    end
                end
                else if (req.reg_addr == ADDR_PRESCALE)
                begin
                    if (asleep)
                    begin
                        prescale_next = req.wr_byte;
                    end
                end
            end
            OP_READ:
            begin
                if (req.reg_addr == ADDR_MODE1)
                begin
                    rd_byte_next = mode1_reg;
                end
                else if (req.reg_addr == ADDR_MODE2)
                begin
                    rd_byte_next = mode2_reg;
                end
                else if (led_hit)
                begin
                    for (int n = 0; n < NUM_CHANNELS; n++)
                    begin
                        if (led_off[7:2] == 6'(n))
                        begin
                            if (led_off[1])
                            begin
                                rd_byte_next = get_led_byte(off_reg[n], led_off[0]);
                            end
                            else
                            begin
                                rd_byte_next = get_led_byte(on_reg[n], led_off[0]);
                            end
                        end
                    end
                end
                else if (req.reg_addr == ADDR_PRESCALE)
                begin
                    rd_byte_next = prescale_reg;
                end
            end
            default:
            begin
                rd_byte_next = 8'h00;
            end
        endcase
    end

    // Channel levels are taken from the state as it stands after this item.
    always_comb
    begin
        lines_next = '0;
        for (int n = 0; n < NUM_CHANNELS; n++)
        begin
            if (on_next[n] <= off_next[n])
            begin
                lines_next[n] = (period_next >= on_next[n]) && (period_next < off_next[n]);
            end
            else
            begin
                lines_next[n] = (period_next >= on_next[n]) || (period_next < off_next[n]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode1_reg     <= MODE1_RESET;
            mode2_reg     <= MODE2_RESET;
            prescale_reg  <= PRESCALE_RESET;
            div_reg       <= 8'h00;
            period_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int n = 0; n < NUM_CHANNELS; n++)
            begin
                on_reg[n]  <= '0;
                off_reg[n] <= '0;
            end
        end
        else
        begin
            if (accept)
            begin
                mode1_reg    <= mode1_next;
                mode2_reg    <= mode2_next;
                prescale_reg <= prescale_next;
                div_reg      <= div_next;
                period_reg   <= period_next;
                for (int n = 0; n < NUM_CHANNELS; n++)
                begin
                    on_reg[n]  <= on_next[n];
                    off_reg[n] <= off_next[n];
                end
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_byte_reg <= rd_byte_next;
            lines_reg   <= lines_next;
        end
    end

endmodule

`default_nettype wire

// File: design/scpwm_checker.sv
`default_nettype none

module scpwm_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 req_valid,
    input wire logic                 req_ready,
    input wire scpwm_pkg::op_t       req_op,
    input wire logic                 rsp_valid,
    input wire logic                 rsp_ready,
    input wire logic [7:0]           rsp_rd_byte,
    input wire logic [15:0]          rsp_pwm_lines
);
    import scpwm_pkg::*;

    // Every accepted item produces a result in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> rsp_valid)
        else $error("accepted item produced no result");

    // Only reads return data.
    a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req_op != OP_READ) |=> (rsp_rd_byte == 8'h00))
        else $error("nonzero read data for a tick or write");

    // The output slot is refilled while it drains, so input never stalls needlessly.
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        (!rsp_valid || rsp_ready) |-> req_ready)
        else $error("input stalled while output could take a result");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
            (rsp_valid && $stable(rsp_rd_byte) && $stable(rsp_pwm_lines)))
        else $error("stalled result changed");

endmodule

bind sixteen_channel_pwm_register_device scpwm_checker u_scpwm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .req_op        (req.op),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_rd_byte   (rsp.rd_byte),
    .rsp_pwm_lines (rsp.pwm_lines)
);

`default_nettype wire
